// File: src/csu_pkg.sv
// ----------------------------------------------------------------------------
// csu_pkg
// Shared types and constants for the cosine similarity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package csu_pkg;

  localparam int unsigned MAX_TERMS_DEF = 1024;
  localparam int unsigned WEIGHT_BITS   = 16;
  localparam int unsigned W_FIELD       = 16;
  localparam int unsigned ACC_BITS      = 42;
  localparam int unsigned MUL_BITS      = 32;
  localparam int unsigned LACC_BITS     = 128;
  localparam int unsigned OPA_BITS      = 96;
  localparam int unsigned OPB_BITS      = 64;
  localparam int unsigned PROD2_BITS    = 2 * ACC_BITS;
  localparam int unsigned SIM_BITS      = 16;

  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
  localparam logic [W_FIELD-1:0]  WEIGHT_MASK =
    (WEIGHT_BITS >= W_FIELD) ? '1 : W_FIELD'((32'd1 << WEIGHT_BITS) - 32'd1);
  localparam logic [3:0] SIM_TOP = 4'd15;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_QQ    = 9'b000000010,
    S_DD    = 9'b000000100,
    S_DRAIN = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_LMUL  = 9'b000100000,
    S_LW    = 9'b001000000,
    S_LEND  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  typedef enum logic [3:0] {
    PH_P  = 4'b0001,
    PH_R  = 4'b0010,
    PH_SQ = 4'b0100,
    PH_L  = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    TAG_NONE = 3'd0,
    TAG_DOT  = 3'd1,
    TAG_QSQ  = 3'd2,
    TAG_DSQ  = 3'd3,
    TAG_LONG = 3'd4
  } mul_tag_e;

  typedef struct packed {
    mul_tag_e   kind;
    logic [1:0] sh;
  } mul_tag_t;

  typedef struct packed {
    logic clear_sums;
    logic clear_long;
    logic set_ovf;
  } acc_ctrl_t;

  typedef struct packed {
    logic [ACC_BITS-1:0] dot;
    logic [ACC_BITS-1:0] qsq;
    logic [ACC_BITS-1:0] dsq;
    logic                ovf;
  } sums_t;

endpackage

`default_nettype wire

// File: src/csu_mul.sv
// ----------------------------------------------------------------------------
// csu_mul
// Shared 32x32 multiplier with a registered product and a tag that follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module csu_mul (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [csu_pkg::MUL_BITS-1:0]     a_i,
  input  wire logic [csu_pkg::MUL_BITS-1:0]     b_i,
  input  wire csu_pkg::mul_tag_t                tag_i,
  output logic      [2*csu_pkg::MUL_BITS-1:0]   prod_o,
  output csu_pkg::mul_tag_t                     tag_o
);

  logic [2*csu_pkg::MUL_BITS-1:0] prod_d, prod_q;
  csu_pkg::mul_tag_t              tag_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '{kind: csu_pkg::TAG_NONE, sh: 2'd0};
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

`default_nettype wire

// File: src/csu_accum.sv
// ----------------------------------------------------------------------------
// csu_accum
// Saturating running sums and the wide accumulator for long multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module csu_accum (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [2*csu_pkg::MUL_BITS-1:0]    prod_i,
  input  wire csu_pkg::mul_tag_t                 tag_i,
  input  wire csu_pkg::acc_ctrl_t                ctrl_i,
  output csu_pkg::sums_t                         sums_o,
  output logic      [csu_pkg::LACC_BITS-1:0]     lacc_o
);

  logic [csu_pkg::ACC_BITS-1:0]  dot_q, dot_d, qsq_q, qsq_d, dsq_q, dsq_d;
  logic                          ovf_q, ovf_d;
  logic [csu_pkg::LACC_BITS-1:0] lacc_q, lacc_d;
  logic [csu_pkg::ACC_BITS-1:0]  sel_acc, sat_res;
  logic [csu_pkg::ACC_BITS:0]    sum;
  logic                          sat;

  always_comb begin
    case (tag_i.kind)
      csu_pkg::TAG_DOT: sel_acc = dot_q;
      csu_pkg::TAG_QSQ: sel_acc = qsq_q;
      csu_pkg::TAG_DSQ: sel_acc = dsq_q;
      default:          sel_acc = '0;
    endcase
    sum     = {1'b0, sel_acc} + (csu_pkg::ACC_BITS + 1)'(prod_i[csu_pkg::MUL_BITS-1:0]);
    sat     = sum[csu_pkg::ACC_BITS];
    sat_res = sat ? csu_pkg::ACC_MAX : sum[csu_pkg::ACC_BITS-1:0];
  end

  always_comb begin
    dot_d  = dot_q;
    qsq_d  = qsq_q;
    dsq_d  = dsq_q;
    ovf_d  = ovf_q;
    lacc_d = lacc_q;
    case (tag_i.kind)
      csu_pkg::TAG_DOT:  dot_d = sat_res;
      csu_pkg::TAG_QSQ:  qsq_d = sat_res;
      csu_pkg::TAG_DSQ:  dsq_d = sat_res;
      csu_pkg::TAG_LONG: lacc_d = lacc_q +
        (csu_pkg::LACC_BITS'(prod_i) << {tag_i.sh, 5'd0});
      default: ;
    endcase
    if (tag_i.kind inside {csu_pkg::TAG_DOT, csu_pkg::TAG_QSQ, csu_pkg::TAG_DSQ} && sat) begin
      ovf_d = 1'b1;
    end
    if (ctrl_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (ctrl_i.clear_sums) begin
      dot_d = '0;
      qsq_d = '0;
      dsq_d = '0;
      ovf_d = 1'b0;
    end
    if (ctrl_i.clear_long) begin
      lacc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      qsq_q <= '0;
      dsq_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      dot_q <= dot_d;
      qsq_q <= qsq_d;
      dsq_q <= dsq_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lacc_q <= lacc_d;
  end

  assign sums_o = '{dot: dot_q, qsq: qsq_q, dsq: dsq_q, ovf: ovf_q};
  assign lacc_o = lacc_q;

endmodule

`default_nettype wire

// File: src/csu_ctrl.sv
// ----------------------------------------------------------------------------
// csu_ctrl
// Sequencer: pair intake, long multiplies, bitwise cosine search, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module csu_ctrl #(
  parameter int unsigned MAX_TERMS = csu_pkg::MAX_TERMS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [2*csu_pkg::W_FIELD-1:0]     s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic      [csu_pkg::SIM_BITS-1:0]      m_axis_tdata_o,
  output logic      [1:0]                        m_axis_tuser_o,
  output logic      [csu_pkg::MUL_BITS-1:0]      mul_a_o,
  output logic      [csu_pkg::MUL_BITS-1:0]      mul_b_o,
  output csu_pkg::mul_tag_t                      mul_tag_o,
  output csu_pkg::acc_ctrl_t                     acc_ctrl_o,
  input  wire csu_pkg::sums_t                    sums_i,
  input  wire logic [csu_pkg::LACC_BITS-1:0]     lacc_i
);

  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);

  csu_pkg::state_e state_q, state_d;
  csu_pkg::phase_e phase_q, phase_d;

  logic [csu_pkg::W_FIELD-1:0]    q_in, d_in, q_q, q_d, d_q, d_d;
  logic                           last_q, last_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [csu_pkg::OPA_BITS-1:0]   op_a_q, op_a_d;
  logic [csu_pkg::OPB_BITS-1:0]   op_b_q, op_b_d;
  logic [1:0]                     imax_q, imax_d, i_q, i_d;
  logic                           jmax_q, jmax_d, j_q, j_d;
  logic [csu_pkg::PROD2_BITS-1:0] p_q, p_d, r_q, r_d;
  logic [csu_pkg::SIM_BITS-1:0]   s_q, s_d, res_q, res_d;
  logic [3:0]                     b_q, b_d, b_new;
  logic                           zero_q, zero_d;
  logic                           out_valid_q, out_valid_d;
  logic [csu_pkg::SIM_BITS-1:0]   out_sim_q, out_sim_d;
  logic                           out_zero_q, out_zero_d, out_ovf_q, out_ovf_d;
  logic                           accept, fits, search_done;
  logic [csu_pkg::SIM_BITS-1:0]   trial, s_new, t_next, t_first;

  assign q_in   = s_axis_tdata_i[csu_pkg::W_FIELD-1:0] & csu_pkg::WEIGHT_MASK;
  assign d_in   = s_axis_tdata_i[2*csu_pkg::W_FIELD-1:csu_pkg::W_FIELD] & csu_pkg::WEIGHT_MASK;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == csu_pkg::S_IDLE);

  assign fits = (lacc_i <= {14'd0, r_q, 30'd0});
  assign trial       = s_q | (csu_pkg::SIM_BITS'(1) << b_q);
  assign s_new       = fits ? trial : s_q;
  assign search_done = (b_q == csu_pkg::SIM_TOP && fits) || (b_q == 4'd0);
  assign b_new       = b_q - 4'd1;
  assign t_next      = s_new | (csu_pkg::SIM_BITS'(1) << b_new);
  assign t_first     = csu_pkg::SIM_BITS'(1) << csu_pkg::SIM_TOP;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    q_d         = q_q;
    d_d         = d_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    imax_d      = imax_q;
    jmax_d      = jmax_q;
    i_d         = i_q;
    j_d         = j_q;
    p_d         = p_q;
    r_d         = r_q;
    s_d         = s_q;
    b_d         = b_q;
    res_d       = res_q;
    zero_d      = zero_q;
    out_sim_d   = out_sim_q;
    out_zero_d  = out_zero_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    mul_a_o     = '0;
    mul_b_o     = '0;
    mul_tag_o   = '{kind: csu_pkg::TAG_NONE, sh: 2'd0};
    acc_ctrl_o  = '0;

    case (state_q)
      csu_pkg::S_IDLE: begin
        if (accept) begin
          if (cnt_q >= CNT_W'(MAX_TERMS)) begin
            acc_ctrl_o.set_ovf = 1'b1;
            state_d = s_axis_tlast_i ? csu_pkg::S_CHK : csu_pkg::S_IDLE;
          end else begin
            cnt_d     = cnt_q + CNT_W'(1);
            q_d       = q_in;
            d_d       = d_in;
            last_d    = s_axis_tlast_i;
            mul_a_o   = csu_pkg::MUL_BITS'(q_in);
            mul_b_o   = csu_pkg::MUL_BITS'(d_in);
            mul_tag_o = '{kind: csu_pkg::TAG_DOT, sh: 2'd0};
            state_d   = csu_pkg::S_QQ;
          end
        end
      end
      csu_pkg::S_QQ: begin
        mul_a_o   = csu_pkg::MUL_BITS'(q_q);
        mul_b_o   = csu_pkg::MUL_BITS'(q_q);
        mul_tag_o = '{kind: csu_pkg::TAG_QSQ, sh: 2'd0};
        state_d   = csu_pkg::S_DD;
      end
      csu_pkg::S_DD: begin
        mul_a_o   = csu_pkg::MUL_BITS'(d_q);
        mul_b_o   = csu_pkg::MUL_BITS'(d_q);
        mul_tag_o = '{kind: csu_pkg::TAG_DSQ, sh: 2'd0};
        state_d   = last_q ? csu_pkg::S_DRAIN : csu_pkg::S_IDLE;
      end
      csu_pkg::S_DRAIN: begin
        state_d = csu_pkg::S_CHK;
      end
      csu_pkg::S_CHK: begin
        if (sums_i.qsq == '0 || sums_i.dsq == '0) begin
          res_d   = '0;
          zero_d  = 1'b1;
          state_d = csu_pkg::S_OUT;
        end else begin
          zero_d  = 1'b0;
          phase_d = csu_pkg::PH_P;
          op_a_d  = csu_pkg::OPA_BITS'(sums_i.qsq);
          op_b_d  = csu_pkg::OPB_BITS'(sums_i.dsq);
          imax_d  = 2'd1;
          jmax_d  = 1'b1;
          i_d     = 2'd0;
          j_d     = 1'b0;
          acc_ctrl_o.clear_long = 1'b1;
          state_d = csu_pkg::S_LMUL;
        end
      end
      csu_pkg::S_LMUL: begin
        mul_a_o   = op_a_q[csu_pkg::MUL_BITS*i_q +: csu_pkg::MUL_BITS];
        mul_b_o   = op_b_q[csu_pkg::MUL_BITS*j_q +: csu_pkg::MUL_BITS];
        mul_tag_o = '{kind: csu_pkg::TAG_LONG, sh: i_q + 2'(j_q)};
        if (j_q != jmax_q) begin
          j_d = 1'b1;
        end else begin
          j_d = 1'b0;
          if (i_q == imax_q) begin
            state_d = csu_pkg::S_LW;
          end else begin
            i_d = i_q + 2'd1;
          end
        end
      end
      csu_pkg::S_LW: begin
        state_d = csu_pkg::S_LEND;
      end
      csu_pkg::S_LEND: begin
        i_d     = 2'd0;
        j_d     = 1'b0;
        state_d = csu_pkg::S_LMUL;
        acc_ctrl_o.clear_long = 1'b1;
        case (phase_q)
          csu_pkg::PH_P: begin
            p_d     = lacc_i[csu_pkg::PROD2_BITS-1:0];
            phase_d = csu_pkg::PH_R;
            op_a_d  = csu_pkg::OPA_BITS'(sums_i.dot);
            op_b_d  = csu_pkg::OPB_BITS'(sums_i.dot);
            imax_d  = 2'd1;
            jmax_d  = 1'b1;
          end
          csu_pkg::PH_R: begin
            r_d     = lacc_i[csu_pkg::PROD2_BITS-1:0];
            s_d     = '0;
            b_d     = csu_pkg::SIM_TOP;
            phase_d = csu_pkg::PH_SQ;
            op_a_d  = csu_pkg::OPA_BITS'(t_first);
            op_b_d  = csu_pkg::OPB_BITS'(t_first);
            imax_d  = 2'd0;
            jmax_d  = 1'b0;
          end
          csu_pkg::PH_SQ: begin
            phase_d = csu_pkg::PH_L;
            op_a_d  = csu_pkg::OPA_BITS'(p_q);
            op_b_d  = csu_pkg::OPB_BITS'(lacc_i[csu_pkg::MUL_BITS-1:0]);
            imax_d  = 2'd2;
            jmax_d  = 1'b0;
          end
          default: begin
            s_d = s_new;
            if (search_done) begin
              res_d   = s_new;
              state_d = csu_pkg::S_OUT;
              acc_ctrl_o.clear_long = 1'b0;
            end else begin
              b_d     = b_new;
              phase_d = csu_pkg::PH_SQ;
              op_a_d  = csu_pkg::OPA_BITS'(t_next);
              op_b_d  = csu_pkg::OPB_BITS'(t_next);
              imax_d  = 2'd0;
              jmax_d  = 1'b0;
            end
          end
        endcase
      end
      csu_pkg::S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_sim_d   = res_q;
          out_zero_d  = zero_q;
          out_ovf_d   = sums_i.ovf;
          cnt_d       = '0;
          acc_ctrl_o.clear_sums = 1'b1;
          state_d     = csu_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = csu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csu_pkg::S_IDLE;
      phase_q     <= csu_pkg::PH_P;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= 1'b0;
      imax_q      <= '0;
      jmax_q      <= 1'b0;
      b_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      imax_q      <= imax_d;
      jmax_q      <= jmax_d;
      b_q         <= b_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q        <= q_d;
    d_q        <= d_d;
    op_a_q     <= op_a_d;
    op_b_q     <= op_b_d;
    p_q        <= p_d;
    r_q        <= r_d;
    s_q        <= s_d;
    res_q      <= res_d;
    zero_q     <= zero_d;
    out_sim_q  <= out_sim_d;
    out_zero_q <= out_zero_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_sim_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_zero_q};

endmodule

`default_nettype wire

// File: src/cosine_similarity_unit.sv
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// Cosine similarity of two Q8.8 weight vectors streamed one pair at a time.
// ----------------------------------------------------------------------------
// Input stream: one transaction per element pair, query weight in tdata[15:0],
// document weight in tdata[31:16], tlast on the final pair of the vectors.
// Output stream: one transaction per vector, Q1.15 similarity in tdata, with
// tuser[0] = zero magnitude and tuser[1] = overflow.
// One 32x32 multiplier computes the three products of a pair in turn; a pair
// past the pair limit is not summed and only sets the overflow flag.
// When a sum of squares is zero the result is 0 with tuser[0] set; otherwise
// the search tests the top result bit first and stops there when it fits,
// else it tests all 16 result bits down to bit 0.
// The final result is a bit-by-bit search where each trial is a chain of
// 32-bit partial products through the same multiplier.
// tready is low while a pair or a final result is being computed. A finished
// result waits in the output register; pairs of the next vector are accepted
// meanwhile, and only the next final result waits for the receiver.
// Reset clears all sums, the pair count and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_unit #(
  parameter int unsigned MAX_TERMS = csu_pkg::MAX_TERMS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [15:0] query_weight, [31:16] doc_weight
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o,  // [15:0] similarity
  output logic      [1:0]  m_axis_tuser_o   // [0] zero_magnitude, [1] overflow
);

  logic [csu_pkg::MUL_BITS-1:0]   mul_a, mul_b;
  logic [2*csu_pkg::MUL_BITS-1:0] prod;
  csu_pkg::mul_tag_t              tag_req, tag_res;
  csu_pkg::acc_ctrl_t             acc_ctrl;
  csu_pkg::sums_t                 sums;
  logic [csu_pkg::LACC_BITS-1:0]  lacc;

  csu_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .mul_a_o         (mul_a),
    .mul_b_o         (mul_b),
    .mul_tag_o       (tag_req),
    .acc_ctrl_o      (acc_ctrl),
    .sums_i          (sums),
    .lacc_i          (lacc)
  );

  csu_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .tag_i  (tag_req),
    .prod_o (prod),
    .tag_o  (tag_res)
  );

  csu_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .prod_i (prod),
    .tag_i  (tag_res),
    .ctrl_i (acc_ctrl),
    .sums_o (sums),
    .lacc_o (lacc)
  );

endmodule

`default_nettype wire

// File: src/csu_checker.sv
// ----------------------------------------------------------------------------
// csu_checker
// Port-level checks for the cosine similarity unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        s_axis_tlast_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output transaction changed while stalled");

  a_sim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o <= 16'h8000)
    else $error("similarity above 1.0");

  a_zero_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == 16'd0)
    else $error("zero magnitude with nonzero similarity");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("ready after last pair");

endmodule

bind cosine_similarity_unit csu_checker u_csu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams query/document weight vectors into cosine_similarity_unit and
// checks every similarity result against an integer model of the cosine.
// Covers extreme weights, zero magnitudes, parallel and orthogonal vectors,
// the pair limit, random traffic under sender and receiver idling, and a
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned MAX_PAIRS = csu_pkg::MAX_TERMS_DEF;

  typedef struct packed {
    logic [15:0] sim;
    logic        zero;
    logic        ovf;
  } cos_result_t;

  typedef enum int {
    VEC_RANDOM,
    VEC_SMALL,
    VEC_SCALED,
    VEC_SPARSE,
    VEC_QUERY_ZERO,
    VEC_DOC_ZERO
  } vec_kind_e;

  class cosine_scoreboard;
    logic [csu_pkg::ACC_BITS-1:0] dot_acc;
    logic [csu_pkg::ACC_BITS-1:0] qsq_acc;
    logic [csu_pkg::ACC_BITS-1:0] dsq_acc;
    int unsigned                  pairs;
    bit                           ovf_seen;
    cos_result_t                  expected_q[$];
    int                           errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      dot_acc  = '0;
      qsq_acc  = '0;
      dsq_acc  = '0;
      pairs    = 0;
      ovf_seen = 1'b0;
    endfunction

    function logic [csu_pkg::ACC_BITS-1:0] sat_add(logic [csu_pkg::ACC_BITS-1:0] acc,
                                                   logic [31:0] p);
      logic [csu_pkg::ACC_BITS:0] s;
      s = {1'b0, acc} + (csu_pkg::ACC_BITS + 1)'(p);
      if (s[csu_pkg::ACC_BITS]) begin
        ovf_seen = 1'b1;
        return '1;
      end
      return s[csu_pkg::ACC_BITS-1:0];
    endfunction

    // s*s*q*d <= dot*dot*2^30
    function bit fits(logic [16:0] s, logic [127:0] rhs);
      logic [127:0] lhs;
      lhs = 128'(s) * 128'(s) * 128'(qsq_acc) * 128'(dsq_acc);
      return lhs <= rhs;
    endfunction

    function logic [15:0] cosine();
      logic [127:0] rhs;
      logic [16:0]  s;
      logic [16:0]  t;
      rhs = (128'(dot_acc) * 128'(dot_acc)) << 30;
      if (fits(17'd32768, rhs)) return 16'd32768;
      s = '0;
      for (int b = 14; b >= 0; b--) begin
        t = s | (17'd1 << b);
        if (fits(t, rhs)) s = t;
      end
      return s[15:0];
    endfunction

    function void note_pair(logic [15:0] q, logic [15:0] d, logic last);
      logic [15:0] qm;
      logic [15:0] dm;
      cos_result_t r;
      qm = q & csu_pkg::WEIGHT_MASK;
      dm = d & csu_pkg::WEIGHT_MASK;
      if (pairs >= MAX_PAIRS) begin
        ovf_seen = 1'b1;
      end else begin
        pairs++;
        dot_acc = sat_add(dot_acc, 32'(qm) * 32'(dm));
        qsq_acc = sat_add(qsq_acc, 32'(qm) * 32'(qm));
        dsq_acc = sat_add(dsq_acc, 32'(dm) * 32'(dm));
      end
      if (!last) return;
      r.zero = (qsq_acc == '0) || (dsq_acc == '0);
      r.sim  = r.zero ? 16'd0 : cosine();
      r.ovf  = ovf_seen;
      expected_q = {expected_q, r};
      clear();
    endfunction

    function void check_result(logic [15:0] sim, logic zero, logic ovf);
      cos_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: similarity %0d", sim);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (sim !== e.sim) begin
        $error("similarity: expected %0d, actual %0d", e.sim, sim);
        errors++;
      end
      if (zero !== e.zero) begin
        $error("zero_magnitude: expected %0d, actual %0d", e.zero, zero);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflow: expected %0d, actual %0d", e.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] query_weight, [31:16] doc_weight
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] similarity
  logic [1:0]  m_axis_tuser;   // [0] zero_magnitude, [1] overflow

  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  int unsigned hold_left;

  cosine_scoreboard sb = new();

  cosine_similarity_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: check each transaction, then pick next tready
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  task automatic send_pair(logic [15:0] q, logic [15:0] d, logic last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, q};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pair(q, d, last);
  endtask

  task automatic send_vector(int len, vec_kind_e kind);
    logic [15:0] q;
    logic [15:0] d;
    int unsigned scale;
    scale = $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      case (kind)
        VEC_SMALL: begin
          q = 16'($urandom_range(0, 255));
          d = 16'($urandom_range(0, 255));
        end
        VEC_SCALED: begin
          q = 16'($urandom_range(0, 16383));
          d = 16'(q * scale);
        end
        VEC_SPARSE: begin
          q = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535));
          d = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535));
        end
        VEC_QUERY_ZERO: begin
          q = 16'd0;
          d = 16'($urandom_range(0, 65535));
        end
        VEC_DOC_ZERO: begin
          q = 16'($urandom_range(0, 65535));
          d = 16'd0;
        end
        default: begin
          q = 16'($urandom_range(0, 65535));
          d = 16'($urandom_range(0, 65535));
        end
      endcase
      send_pair(q, d, i == len - 1);
    end
  endtask

  task automatic run_phase(int unsigned snd, int unsigned rcv, int items);
    int sent;
    int len;
    int pick;
    vec_kind_e kind;
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    sent = 0;
    while (sent < items) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      pick = $urandom_range(0, 19);
      if (pick < 10)      kind = VEC_RANDOM;
      else if (pick < 12) kind = VEC_SMALL;
      else if (pick < 14) kind = VEC_SCALED;
      else if (pick < 17) kind = VEC_SPARSE;
      else if (pick < 18) kind = VEC_QUERY_ZERO;
      else if (pick < 19) kind = VEC_DOC_ZERO;
      else                kind = vec_kind_e'($urandom_range(0, 5));
      send_vector(len, kind);
      sent += len;
    end
  endtask

  initial begin
    int drain;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_left     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: parallel, extremes, zero magnitudes, orthogonal
    send_pair(16'h0100, 16'h0100, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'h0001, 16'h0001, 1'b1);
    send_pair(16'h0000, 16'h1234, 1'b0);
    send_pair(16'h0000, 16'h0005, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b1);
    send_pair(16'h0100, 16'h0200, 1'b0);
    send_pair(16'h0300, 16'h0080, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    send_pair(16'h0001, 16'h0002, 1'b0);
    send_pair(16'h0003, 16'h0006, 1'b0);
    send_pair(16'h7FFF, 16'hFFFE, 1'b1);
    send_pair(16'h0001, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'h0001, 1'b1);

    // pair limit: fill it, then two pairs past it
    send_vector(MAX_PAIRS + 2, VEC_RANDOM);

    run_phase(0, 0, 20);
    run_phase(69, 0, 20);
    run_phase(0, 69, 20);
    run_phase(21, 21, 20);

    // long receiver hold-off while the sender keeps pushing
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_left     = 600;
    for (int v = 0; v < 8; v++) send_vector(3, VEC_RANDOM);

    s_axis_tvalid <= 1'b0;
    rcv_stall_pct = 0;

    drain = 0;
    while (sb.pending() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (200) @(posedge clk_i);

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
